>>> rtl/lbmeq_pkg.sv
package lbmeq_pkg;

    localparam int SITE_ADDR_BITS_DEF = 20;
    localparam int DIR_W              = 5;
    localparam int CVEL_W             = 2;
    localparam int DATA_W             = 32;
    localparam int CFG_IDX_W          = 1;
    localparam int NSTAGE             = 17;

    localparam int UD_W      = 35;
    localparam int UD_MAG_W  = 34;
    localparam int USQ_W     = 63;
    localparam int PROD_W    = 64;
    localparam int UU_W      = 34;
    localparam int RW_W      = 32;
    localparam int I2_W      = 36;
    localparam int SQ_W      = 38;
    localparam int CU_W      = 34;
    localparam int A1_MAG_W  = 38;
    localparam int A1_W      = 39;
    localparam int S_W       = 39;
    localparam int S_MAG_W   = 38;
    localparam int TA_W      = 39;
    localparam int A2_MAG_W  = 45;
    localparam int A2_W      = 46;
    localparam int T_W       = 46;
    localparam int T_MAG_W   = 45;
    localparam int F_MAG_W   = 48;

    localparam logic [CVEL_W-1:0] CVEL_ZERO = 2'b00;
    localparam logic [CVEL_W-1:0] CVEL_POS  = 2'b01;
    localparam logic [CVEL_W-1:0] CVEL_NEG2 = 2'b10;
    localparam logic [CVEL_W-1:0] CVEL_NEG  = 2'b11;

    localparam logic [CFG_IDX_W-1:0] REG_SOUND_SPEED_SQ     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SOUND_SPEED_SQ = 1'b1;

    localparam logic [DATA_W-1:0] EQ_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] EQ_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [DATA_W-1:0] sound_speed_sq;
        logic [DATA_W-1:0] inv_sound_speed_sq;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        sound_speed_sq:     32'h5555_5555,
        inv_sound_speed_sq: 32'h3000_0000
    };

    typedef struct packed {
        logic [NSTAGE-1:0] load;
    } pipe_ctl_t;

endpackage

>>> rtl/lbmeq_cfg_regs.sv
module lbmeq_cfg_regs
    import lbmeq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_write_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write_en) begin
            unique case (cfg_index)
                REG_SOUND_SPEED_SQ: begin
                    cfg_next.sound_speed_sq = cfg_write_data;
                end
                REG_INV_SOUND_SPEED_SQ: begin
                    cfg_next.inv_sound_speed_sq = cfg_write_data;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/lbmeq_pipe_ctrl.sv
module lbmeq_pipe_ctrl
    import lbmeq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output pipe_ctl_t ctl
);

    localparam logic [NSTAGE-1:0] ALL_VALID = '1;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] load;

    // a stage may load when some stage at or after it is empty or the item leaves
    always_comb begin
        for (int k = 0; k < NSTAGE; k++) begin
            load[k] = m_ready || ((valid_reg >> k) != (ALL_VALID >> k));
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load[0]) begin
            valid_next[0] = s_valid;
        end
        for (int k = 1; k < NSTAGE; k++) begin
            if (load[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.load = load;
    assign s_ready  = load[0];
    assign m_valid  = valid_reg[NSTAGE-1];

endmodule

>>> rtl/lbmeq_mul.sv
module lbmeq_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic               aclk,
    input  logic               load_pp,
    input  logic               load_sum,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] p
);

    localparam int LO_W = (B_W + 1) / 2;
    localparam int HI_W = B_W - LO_W;
    localparam int P_W  = A_W + B_W;

    logic [A_W+LO_W-1:0] pl_reg;
    logic [A_W+LO_W-1:0] pl_next;
    logic [A_W+HI_W-1:0] ph_reg;
    logic [A_W+HI_W-1:0] ph_next;
    logic [P_W-1:0]      p_reg;
    logic [P_W-1:0]      p_next;

    assign pl_next = (A_W+LO_W)'(a) * (A_W+LO_W)'(b[LO_W-1:0]);
    assign ph_next = (A_W+HI_W)'(a) * (A_W+HI_W)'(b[B_W-1:LO_W]);
    assign p_next  = P_W'(pl_reg) + (P_W'(ph_reg) << LO_W);

    always_ff @(posedge aclk) begin
        if (load_pp) begin
            pl_reg <= pl_next;
            ph_reg <= ph_next;
        end
        if (load_sum) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

>>> rtl/lbmeq_datapath.sv
module lbmeq_datapath
    import lbmeq_pkg::*;
#(
    parameter int SITE_ADDR_BITS = SITE_ADDR_BITS_DEF
) (
    input  logic                      aclk,
    input  pipe_ctl_t                 ctl,
    input  cfg_t                      cfg,
    input  logic [SITE_ADDR_BITS-1:0] s_site_address,
    input  logic [DIR_W-1:0]          s_direction,
    input  logic signed [CVEL_W-1:0]  s_cvel_x,
    input  logic signed [CVEL_W-1:0]  s_cvel_y,
    input  logic signed [CVEL_W-1:0]  s_cvel_z,
    input  logic [DATA_W-1:0]         s_weight,
    input  logic [DATA_W-1:0]         s_density,
    input  logic signed [DATA_W-1:0]  s_vel_x,
    input  logic signed [DATA_W-1:0]  s_vel_y,
    input  logic signed [DATA_W-1:0]  s_vel_z,
    input  logic                      s_last_link,
    output logic [SITE_ADDR_BITS-1:0] m_out_address,
    output logic [DIR_W-1:0]          m_out_direction,
    output logic signed [DATA_W-1:0]  m_equilibrium,
    output logic                      m_saturated,
    output logic                      m_out_last
);

    localparam int SQP_W = 2 * UD_MAG_W;
    localparam int CUP_W = DATA_W + UU_W;
    localparam int A1P_W = DATA_W + UD_MAG_W;
    localparam int A2P_W = I2_W + S_MAG_W;
    localparam int FP_W  = RW_W + T_MAG_W;

    function automatic logic signed [UD_W-1:0] cvel_term(
        input logic [CVEL_W-1:0]        c,
        input logic signed [DATA_W-1:0] u
    );
        logic signed [UD_W-1:0] ue;
        logic signed [UD_W-1:0] res;
        ue = UD_W'(u);
        case (c)
            CVEL_ZERO: res = '0;
            CVEL_POS:  res = ue;
            CVEL_NEG:  res = -ue;
            CVEL_NEG2: res = -(ue <<< 1);
        endcase
        return res;
    endfunction

    // pass-through fields
    logic [SITE_ADDR_BITS-1:0] addr_reg [NSTAGE];
    logic [DIR_W-1:0]          dir_reg  [NSTAGE];
    logic [NSTAGE-1:0]         last_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            addr_reg[0] <= s_site_address;
            dir_reg[0]  <= s_direction;
            last_reg[0] <= s_last_link;
        end
        for (int k = 1; k < NSTAGE; k++) begin
            if (ctl.load[k]) begin
                addr_reg[k] <= addr_reg[k-1];
                dir_reg[k]  <= dir_reg[k-1];
                last_reg[k] <= last_reg[k-1];
            end
        end
    end

    // stage 0: input capture
    logic [CVEL_W-1:0]        cvel_reg [3];
    logic signed [DATA_W-1:0] vel_reg  [3];
    logic [DATA_W-1:0]        weight_reg;
    logic [DATA_W-1:0]        density_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            cvel_reg[0] <= s_cvel_x;
            cvel_reg[1] <= s_cvel_y;
            cvel_reg[2] <= s_cvel_z;
            vel_reg[0]  <= s_vel_x;
            vel_reg[1]  <= s_vel_y;
            vel_reg[2]  <= s_vel_z;
            weight_reg  <= s_weight;
            density_reg <= s_density;
        end
    end

    // stage 1: u.c, squares of u, rho*w, inv*inv
    logic signed [2*DATA_W-1:0] vel_wide [3];
    logic [USQ_W-1:0]           usq_next [3];
    logic [USQ_W-1:0]           usq_reg  [3];
    logic signed [UD_W-1:0]     ud_next;
    logic signed [UD_W-1:0]     ud_reg;
    logic [PROD_W-1:0]          prw_next;
    logic [PROD_W-1:0]          prw_reg;
    logic [PROD_W-1:0]          ip_next;
    logic [PROD_W-1:0]          ip_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vel_wide[i] = (2*DATA_W)'(vel_reg[i]);
            usq_next[i] = USQ_W'(vel_wide[i] * vel_wide[i]);
        end
        ud_next = cvel_term(cvel_reg[0], vel_reg[0])
                + cvel_term(cvel_reg[1], vel_reg[1])
                + cvel_term(cvel_reg[2], vel_reg[2]);
        prw_next = PROD_W'(density_reg) * PROD_W'(weight_reg);
        ip_next  = PROD_W'(cfg.inv_sound_speed_sq) * PROD_W'(cfg.inv_sound_speed_sq);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[1]) begin
            usq_reg <= usq_next;
            ud_reg  <= ud_next;
            prw_reg <= prw_next;
            ip_reg  <= ip_next;
        end
    end

    // stage 2: rounding of |u|^2, rho*w, inv^2; magnitude of u.c
    logic [PROD_W-1:0]   uu_sum;
    logic [PROD_W-1:0]   rw_sum;
    logic [PROD_W-1:0]   i2_sum;
    logic [UD_W-1:0]     ud_abs;
    logic [UU_W-1:0]     uu_next;
    logic [UU_W-1:0]     uu_reg;
    logic [RW_W-1:0]     rw_next;
    logic [RW_W-1:0]     rw_reg [2:12];
    logic [I2_W-1:0]     i2_next;
    logic [I2_W-1:0]     i2_reg [2:7];
    logic [UD_MAG_W-1:0] udmag_next;
    logic [UD_MAG_W-1:0] udmag_reg;
    logic                udneg_next;
    logic                udneg_reg [2:4];

    always_comb begin
        uu_sum = PROD_W'(usq_reg[0]) + PROD_W'(usq_reg[1]) + PROD_W'(usq_reg[2])
               + (PROD_W'(1) << 29);
        uu_next    = uu_sum[30 +: UU_W];
        rw_sum     = prw_reg + (PROD_W'(1) << 31);
        rw_next    = rw_sum[32 +: RW_W];
        i2_sum     = ip_reg + (PROD_W'(1) << 27);
        i2_next    = i2_sum[28 +: I2_W];
        udneg_next = ud_reg[UD_W-1];
        ud_abs     = udneg_next ? -ud_reg : ud_reg;
        udmag_next = ud_abs[UD_MAG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            uu_reg       <= uu_next;
            rw_reg[2]    <= rw_next;
            i2_reg[2]    <= i2_next;
            udmag_reg    <= udmag_next;
            udneg_reg[2] <= udneg_next;
        end
        for (int k = 3; k <= 12; k++) begin
            if (ctl.load[k]) begin
                rw_reg[k] <= rw_reg[k-1];
            end
        end
        for (int k = 3; k <= 7; k++) begin
            if (ctl.load[k]) begin
                i2_reg[k] <= i2_reg[k-1];
            end
        end
        for (int k = 3; k <= 4; k++) begin
            if (ctl.load[k]) begin
                udneg_reg[k] <= udneg_reg[k-1];
            end
        end
    end

    // stages 3 and 4: (u.c)^2, cs2*|u|^2, inv*(u.c)
    logic [SQP_W-1:0] sqp;
    logic [CUP_W-1:0] cup;
    logic [A1P_W-1:0] a1p;

    lbmeq_mul #(.A_W(UD_MAG_W), .B_W(UD_MAG_W)) u_mul_sq (
        .aclk     (aclk),
        .load_pp  (ctl.load[3]),
        .load_sum (ctl.load[4]),
        .a        (udmag_reg),
        .b        (udmag_reg),
        .p        (sqp)
    );

    lbmeq_mul #(.A_W(DATA_W), .B_W(UU_W)) u_mul_cu (
        .aclk     (aclk),
        .load_pp  (ctl.load[3]),
        .load_sum (ctl.load[4]),
        .a        (cfg.sound_speed_sq),
        .b        (uu_reg),
        .p        (cup)
    );

    lbmeq_mul #(.A_W(DATA_W), .B_W(UD_MAG_W)) u_mul_a1 (
        .aclk     (aclk),
        .load_pp  (ctl.load[3]),
        .load_sum (ctl.load[4]),
        .a        (cfg.inv_sound_speed_sq),
        .b        (udmag_reg),
        .p        (a1p)
    );

    // stage 5: rounding, sign of the first-order term
    logic [SQP_W:0]         sq_sum;
    logic [CUP_W:0]         cu_sum;
    logic [A1P_W:0]         a1_sum;
    logic signed [A1_W-1:0] a1_pos;
    logic [SQ_W-1:0]        sq_next;
    logic [SQ_W-1:0]        sq_reg;
    logic [CU_W-1:0]        cu_next;
    logic [CU_W-1:0]        cu_reg;
    logic signed [A1_W-1:0] a1_next;
    logic signed [A1_W-1:0] a1_reg;

    always_comb begin
        sq_sum  = {1'b0, sqp} + ((SQP_W+1)'(1) << 29);
        sq_next = sq_sum[30 +: SQ_W];
        cu_sum  = {1'b0, cup} + ((CUP_W+1)'(1) << 31);
        cu_next = cu_sum[32 +: CU_W];
        a1_sum  = {1'b0, a1p} + ((A1P_W+1)'(1) << 27);
        a1_pos  = {1'b0, a1_sum[28 +: A1_MAG_W]};
        a1_next = udneg_reg[4] ? -a1_pos : a1_pos;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[5]) begin
            sq_reg <= sq_next;
            cu_reg <= cu_next;
            a1_reg <= a1_next;
        end
    end

    // stage 6: S:uu and 1 + first-order term
    logic signed [S_W-1:0]  s_next;
    logic signed [S_W-1:0]  s_reg;
    logic signed [TA_W-1:0] ta_next;
    logic signed [TA_W-1:0] ta_reg [6:10];

    always_comb begin
        s_next  = {{(S_W-SQ_W){1'b0}}, sq_reg} - {{(S_W-CU_W){1'b0}}, cu_reg};
        ta_next = a1_reg + (TA_W'(1) << 30);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[6]) begin
            s_reg     <= s_next;
            ta_reg[6] <= ta_next;
        end
        for (int k = 7; k <= 10; k++) begin
            if (ctl.load[k]) begin
                ta_reg[k] <= ta_reg[k-1];
            end
        end
    end

    // stage 7: magnitude of S:uu
    logic [S_W-1:0]     s_abs;
    logic [S_MAG_W-1:0] smag_next;
    logic [S_MAG_W-1:0] smag_reg;
    logic               sneg_next;
    logic               sneg_reg [7:9];

    always_comb begin
        sneg_next = s_reg[S_W-1];
        s_abs     = sneg_next ? -s_reg : s_reg;
        smag_next = s_abs[S_MAG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[7]) begin
            smag_reg    <= smag_next;
            sneg_reg[7] <= sneg_next;
        end
        for (int k = 8; k <= 9; k++) begin
            if (ctl.load[k]) begin
                sneg_reg[k] <= sneg_reg[k-1];
            end
        end
    end

    // stages 8 and 9: inv^2 * S:uu
    logic [A2P_W-1:0] a2p;

    lbmeq_mul #(.A_W(I2_W), .B_W(S_MAG_W)) u_mul_a2 (
        .aclk     (aclk),
        .load_pp  (ctl.load[8]),
        .load_sum (ctl.load[9]),
        .a        (i2_reg[7]),
        .b        (smag_reg),
        .p        (a2p)
    );

    // stage 10: second-order term, half folded into the shift
    logic [A2P_W:0]         a2_sum;
    logic signed [A2_W-1:0] a2_pos;
    logic signed [A2_W-1:0] a2_next;
    logic signed [A2_W-1:0] a2_reg;

    always_comb begin
        a2_sum  = {1'b0, a2p} + ((A2P_W+1)'(1) << 28);
        a2_pos  = {1'b0, a2_sum[29 +: A2_MAG_W]};
        a2_next = sneg_reg[9] ? -a2_pos : a2_pos;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[10]) begin
            a2_reg <= a2_next;
        end
    end

    // stage 11: bracket sum
    logic signed [T_W-1:0] t_next;
    logic signed [T_W-1:0] t_reg;

    assign t_next = T_W'(ta_reg[10]) + a2_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load[11]) begin
            t_reg <= t_next;
        end
    end

    // stage 12: magnitude of the bracket
    logic [T_W-1:0]     t_abs;
    logic [T_MAG_W-1:0] tmag_next;
    logic [T_MAG_W-1:0] tmag_reg;
    logic               tneg_next;
    logic               tneg_reg [12:15];

    always_comb begin
        tneg_next = t_reg[T_W-1];
        t_abs     = tneg_next ? -t_reg : t_reg;
        tmag_next = t_abs[T_MAG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[12]) begin
            tmag_reg     <= tmag_next;
            tneg_reg[12] <= tneg_next;
        end
        for (int k = 13; k <= 15; k++) begin
            if (ctl.load[k]) begin
                tneg_reg[k] <= tneg_reg[k-1];
            end
        end
    end

    // stages 13 and 14: rho*w * bracket
    logic [FP_W-1:0] fp;

    lbmeq_mul #(.A_W(RW_W), .B_W(T_MAG_W)) u_mul_f (
        .aclk     (aclk),
        .load_pp  (ctl.load[13]),
        .load_sum (ctl.load[14]),
        .a        (rw_reg[12]),
        .b        (tmag_reg),
        .p        (fp)
    );

    // stage 15: rounding of the result magnitude
    logic [FP_W:0]      f_sum;
    logic [F_MAG_W-1:0] fmag_next;
    logic [F_MAG_W-1:0] fmag_reg;

    always_comb begin
        f_sum     = {1'b0, fp} + ((FP_W+1)'(1) << 29);
        fmag_next = f_sum[30 +: F_MAG_W];
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[15]) begin
            fmag_reg <= fmag_next;
        end
    end

    // stage 16: saturate and apply sign
    logic              sat_pos;
    logic              sat_neg;
    logic [DATA_W-1:0] eq_next;
    logic [DATA_W-1:0] eq_reg;
    logic              sat_next;
    logic              sat_reg;

    always_comb begin
        sat_pos  = !tneg_reg[15] && (fmag_reg > F_MAG_W'(EQ_MAX));
        sat_neg  = tneg_reg[15] && (fmag_reg > F_MAG_W'(EQ_MIN));
        sat_next = sat_pos || sat_neg;
        if (sat_pos) begin
            eq_next = EQ_MAX;
        end else if (sat_neg) begin
            eq_next = EQ_MIN;
        end else if (tneg_reg[15]) begin
            eq_next = -fmag_reg[DATA_W-1:0];
        end else begin
            eq_next = fmag_reg[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[16]) begin
            eq_reg  <= eq_next;
            sat_reg <= sat_next;
        end
    end

    assign m_out_address   = addr_reg[NSTAGE-1];
    assign m_out_direction = dir_reg[NSTAGE-1];
    assign m_out_last      = last_reg[NSTAGE-1];
    assign m_equilibrium   = eq_reg;
    assign m_saturated     = sat_reg;

endmodule

>>> rtl/lbm_equilibrium_distribution_core.sv
// Throughput: one item per cycle unless the output stalls a full pipeline; the
// 17-stage pipeline with split multipliers takes a new item every cycle while any
// stage is empty or the output accepts, and closes bubbles while the output is stalled.
// Reset (aresetn low, synchronous): all stage valid flags clear and both
// configuration registers return to one third and three.
module lbm_equilibrium_distribution_core
    import lbmeq_pkg::*;
#(
    parameter int SITE_ADDR_BITS = SITE_ADDR_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_write_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [DATA_W-1:0]         cfg_write_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [SITE_ADDR_BITS-1:0] s_site_address,
    input  logic [DIR_W-1:0]          s_direction,
    input  logic signed [CVEL_W-1:0]  s_cvel_x,
    input  logic signed [CVEL_W-1:0]  s_cvel_y,
    input  logic signed [CVEL_W-1:0]  s_cvel_z,
    input  logic [DATA_W-1:0]         s_weight,
    input  logic [DATA_W-1:0]         s_density,
    input  logic signed [DATA_W-1:0]  s_vel_x,
    input  logic signed [DATA_W-1:0]  s_vel_y,
    input  logic signed [DATA_W-1:0]  s_vel_z,
    input  logic                      s_last_link,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [SITE_ADDR_BITS-1:0] m_out_address,
    output logic [DIR_W-1:0]          m_out_direction,
    output logic signed [DATA_W-1:0]  m_equilibrium,
    output logic                      m_saturated,
    output logic                      m_out_last
);

    cfg_t      cfg;
    pipe_ctl_t ctl;

    lbmeq_cfg_regs u_cfg_regs (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_write_data (cfg_write_data),
        .cfg            (cfg)
    );

    lbmeq_pipe_ctrl u_pipe_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    lbmeq_datapath #(.SITE_ADDR_BITS(SITE_ADDR_BITS)) u_datapath (
        .aclk            (aclk),
        .ctl             (ctl),
        .cfg             (cfg),
        .s_site_address  (s_site_address),
        .s_direction     (s_direction),
        .s_cvel_x        (s_cvel_x),
        .s_cvel_y        (s_cvel_y),
        .s_cvel_z        (s_cvel_z),
        .s_weight        (s_weight),
        .s_density       (s_density),
        .s_vel_x         (s_vel_x),
        .s_vel_y         (s_vel_y),
        .s_vel_z         (s_vel_z),
        .s_last_link     (s_last_link),
        .m_out_address   (m_out_address),
        .m_out_direction (m_out_direction),
        .m_equilibrium   (m_equilibrium),
        .m_saturated     (m_saturated),
        .m_out_last      (m_out_last)
    );

endmodule

>>> rtl/lbmeq_checker.sv
module lbmeq_checker
    import lbmeq_pkg::*;
#(
    parameter int SITE_ADDR_BITS = SITE_ADDR_BITS_DEF
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [SITE_ADDR_BITS-1:0] m_out_address,
    input logic [DIR_W-1:0]          m_out_direction,
    input logic signed [DATA_W-1:0]  m_equilibrium,
    input logic                      m_saturated,
    input logic                      m_out_last
);

    a_reset_drains: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_equilibrium)
            && $stable(m_saturated) && $stable(m_out_address)
            && $stable(m_out_direction) && $stable(m_out_last))
        else $error("stalled result item changed");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> (m_equilibrium == EQ_MAX || m_equilibrium == EQ_MIN))
        else $error("saturated flag without a clipped value");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input held off while output drains");

endmodule

bind lbm_equilibrium_distribution_core lbmeq_checker #(
    .SITE_ADDR_BITS(SITE_ADDR_BITS)
) u_lbmeq_checker (.*);
